// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the texture sampler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== rtl/bts_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear texture sampler package
// Shared widths, register indexes and codes.
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int unsigned DIM_W   = 11;
   localparam int unsigned CHAN_W  = 3;
   localparam int unsigned COLOR_W = 16;
   localparam int unsigned BADDR_W = 18;
   localparam int unsigned FRAC_W  = 16;

   localparam logic [COLOR_W-1:0] WHITE_Q88 = 16'hFF00;

   typedef enum logic [2:0] {
      REG_TEXTURE_PRESENT = 3'd0,
      REG_FILTER_MODE     = 3'd1,
      REG_TEX_WIDTH       = 3'd2,
      REG_TEX_HEIGHT      = 3'd3,
      REG_CHANNEL_COUNT   = 3'd4
   } reg_index_type;

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_SAMPLE = 1'b1
   } kind_type;

endpackage

// ===== rtl/bts_ifs.sv =====
// ----------------------------------------------------------------------------
// Sampler channel interfaces
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
interface bts_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [bts_pkg::BADDR_W-1:0]        byte_addr;
   logic [7:0]                         byte_value;
   logic signed [31:0]                 u_coord;
   logic signed [31:0]                 v_coord;

   modport source (output valid, kind, byte_addr, byte_value, u_coord, v_coord,
                   input ready);
   modport sink   (input valid, kind, byte_addr, byte_value, u_coord, v_coord,
                   output ready);
endinterface

interface bts_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bts_pkg::COLOR_W-1:0]   red;
   logic [bts_pkg::COLOR_W-1:0]   green;
   logic [bts_pkg::COLOR_W-1:0]   blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== rtl/bts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two registered read ports with a shared read enable.
// ----------------------------------------------------------------------------
module bts_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr_b,
   output logic [WIDTH-1:0]          rd_data_a,
   output logic [WIDTH-1:0]          rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ===== rtl/bilinear_texture_sampler_core.sv =====
// Sample results leave through the output register; loads return no response.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds in place while the response side stalls.
// Four texels are read in the same cycle from six replicated two-port texel memories.
// Reset (synchronous, active high) clears the stage valid bits and loads the
// configuration reset values; texel memory contents are undefined until loaded.
// ----------------------------------------------------------------------------
// Bilinear texture sampler core
// Nine-stage pipeline: coordinate scaling, neighbor selection, addressing,
// texel fetch, horizontal blend, vertical blend and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_texture_sampler_core #(
   parameter int unsigned TEX_BYTES   = 262144,
   parameter int unsigned WEIGHT_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   bts_req_if.sink              req_if,
   bts_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [bts_pkg::DIM_W-1:0] csr_wdata
);

   localparam int unsigned AW    = $clog2(TEX_BYTES);
   localparam int unsigned DW    = bts_pkg::DIM_W;
   localparam int unsigned FW    = bts_pkg::FRAC_W;
   localparam int unsigned PW    = FW + DW;
   localparam int unsigned OW    = WEIGHT_BITS + 1;
   localparam int unsigned TW    = 8 + OW;
   localparam int unsigned MW    = TW + OW;
   localparam int unsigned SHIFT = 2 * WEIGHT_BITS - 8;

   // Configuration registers.
   logic                              present_ff, filter_ff;
   logic [DW-1:0]                     width_ff, height_ff;
   logic [bts_pkg::CHAN_W-1:0]        chan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         filter_ff  <= 1'b1;
         width_ff   <= DW'(1);
         height_ff  <= DW'(1);
         chan_ff    <= bts_pkg::CHAN_W'(3);
      end else if (csr_we) begin
         unique case (csr_index)
            bts_pkg::REG_TEXTURE_PRESENT: present_ff <= csr_wdata[0];
            bts_pkg::REG_FILTER_MODE:     filter_ff  <= csr_wdata[0];
            bts_pkg::REG_TEX_WIDTH:       width_ff   <= csr_wdata;
            bts_pkg::REG_TEX_HEIGHT:      height_ff  <= csr_wdata;
            bts_pkg::REG_CHANNEL_COUNT:   chan_ff    <= csr_wdata[bts_pkg::CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   logic [DW-1:0]                 eff_w, eff_h, wm1, hm1;
   logic [bts_pkg::CHAN_W-1:0]    eff_c;
   assign eff_w = (width_ff == '0) ? DW'(1) : width_ff;
   assign eff_h = (height_ff == '0) ? DW'(1) : height_ff;
   assign eff_c = (chan_ff == '0) ? bts_pkg::CHAN_W'(1) : chan_ff;
   assign wm1   = eff_w - DW'(1);
   assign hm1   = eff_h - DW'(1);

   logic adv;
   logic [9:1] v_ff;
   logic [8:1] k_ff;

   assign adv          = !v_ff[9] || rsp_if.ready;
   assign req_if.ready = adv;

   // Valid and kind travel with the data; loads drop out at the final stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff[1] <= req_if.valid;
         for (int i = 2; i <= 8; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
         v_ff[9] <= v_ff[8] && (k_ff[8] == bts_pkg::KIND_SAMPLE);
      end
   end

   // Stage 1: input register.
   logic [AW-1:0]  ld_addr_ff [1:6];
   logic [7:0]     ld_val_ff  [1:6];
   logic [FW-1:0]  uf_ff, vf_ff;
   logic [PW-1:0]  px_ff, py_ff;
   logic [DW-1:0]  x0_ff, x1_ff, y0_ff, y1_ff, x0b_ff, x1b_ff;
   logic [WEIGHT_BITS-1:0] wx_ff [3:8];
   logic [WEIGHT_BITS-1:0] wy_ff [3:8];
   logic [AW-1:0]  row0_ff, row1_ff;
   logic [AW-1:0]  idx_ff  [4];
   logic [AW-1:0]  base_ff [4];

   logic [PW-1:0]  x0_full, y0_full;
   logic [DW-1:0]  x0_c, y0_c, x1_c, y1_c;
   assign x0_full = px_ff >> FW;
   assign y0_full = py_ff >> FW;
   assign x0_c = (x0_full > PW'(wm1)) ? wm1 : x0_full[DW-1:0];
   assign y0_c = (y0_full > PW'(hm1)) ? hm1 : y0_full[DW-1:0];
   assign x1_c = ({1'b0, x0_c} + (DW+1)'(1) < {1'b0, eff_w}) ? x0_c + DW'(1) : wm1;
   assign y1_c = ({1'b0, y0_c} + (DW+1)'(1) < {1'b0, eff_h}) ? y0_c + DW'(1) : hm1;

   always_ff @(posedge clock) begin
      if (adv) begin
         k_ff[1]      <= req_if.kind;
         ld_addr_ff[1] <= AW'(req_if.byte_addr);
         ld_val_ff[1]  <= req_if.byte_value;
         uf_ff        <= req_if.u_coord[FW-1:0];
         vf_ff        <= req_if.v_coord[FW-1:0];
         for (int i = 2; i <= 8; i++) begin
            k_ff[i] <= k_ff[i-1];
         end
         for (int i = 2; i <= 6; i++) begin
            ld_addr_ff[i] <= ld_addr_ff[i-1];
            ld_val_ff[i]  <= ld_val_ff[i-1];
         end
         // Stage 2: scale the fractions.
         px_ff <= PW'(uf_ff) * PW'(wm1);
         py_ff <= PW'(vf_ff) * PW'(hm1);
         // Stage 3: neighbors and weights.
         x0_ff    <= x0_c;
         x1_ff    <= x1_c;
         y0_ff    <= y0_c;
         y1_ff    <= y1_c;
         wx_ff[3] <= px_ff[FW-1:FW-WEIGHT_BITS];
         wy_ff[3] <= py_ff[FW-1:FW-WEIGHT_BITS];
         for (int i = 4; i <= 8; i++) begin
            wx_ff[i] <= wx_ff[i-1];
            wy_ff[i] <= wy_ff[i-1];
         end
         // Stage 4: row offsets.
         row0_ff <= AW'(y0_ff * eff_w);
         row1_ff <= AW'(y1_ff * eff_w);
         x0b_ff  <= x0_ff;
         x1b_ff  <= x1_ff;
         // Stage 5: texel indexes, order (x0,y0) (x1,y0) (x0,y1) (x1,y1).
         idx_ff[0] <= row0_ff + AW'(x0b_ff);
         idx_ff[1] <= row0_ff + AW'(x1b_ff);
         idx_ff[2] <= row1_ff + AW'(x0b_ff);
         idx_ff[3] <= row1_ff + AW'(x1b_ff);
         // Stage 6: byte addresses.
         for (int t = 0; t < 4; t++) begin
            base_ff[t] <= AW'(idx_ff[t] * eff_c);
         end
      end
   end

   // Stage 7: texel fetch. Memory copy [p][ch] serves texels 2p and 2p+1.
   logic [7:0] tex_q [4][3];
   logic       ld_we;
   assign ld_we = adv && v_ff[6] && (k_ff[6] == bts_pkg::KIND_LOAD);

   for (genvar p = 0; p < 2; p++) begin : g_pair
      for (genvar ch = 0; ch < 3; ch++) begin : g_chan
         logic [AW-1:0] ra, rb;
         // Missing channels read the red byte again.
         assign ra = (eff_c > bts_pkg::CHAN_W'(ch)) ? base_ff[2*p] + AW'(ch) : base_ff[2*p];
         assign rb = (eff_c > bts_pkg::CHAN_W'(ch)) ?
                     base_ff[2*p+1] + AW'(ch) : base_ff[2*p+1];
         bts_ram #(.WIDTH(8), .DEPTH(TEX_BYTES)) u_ram (
            .clock     (clock),
            .wr_en     (ld_we),
            .wr_addr   (ld_addr_ff[6]),
            .wr_data   (ld_val_ff[6]),
            .rd_en     (adv),
            .rd_addr_a (ra),
            .rd_addr_b (rb),
            .rd_data_a (tex_q[2*p][ch]),
            .rd_data_b (tex_q[2*p+1][ch])
         );
      end
   end

   // Stage 8: horizontal blend. Stage 9: vertical blend and output format.
   logic [TW-1:0] top_ff [3];
   logic [TW-1:0] bot_ff [3];
   logic [7:0]    near_ff [3];
   logic [OW-1:0] wx7_inv, wy8_inv;
   logic [bts_pkg::COLOR_W-1:0] out_ff [3];
   logic [MW-1:0] mix [3];

   assign wx7_inv = (OW'(1) << WEIGHT_BITS) - OW'(wx_ff[7]);
   assign wy8_inv = (OW'(1) << WEIGHT_BITS) - OW'(wy_ff[8]);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mix[k] = MW'(top_ff[k]) * MW'(wy8_inv) + MW'(bot_ff[k]) * MW'(wy_ff[8]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            top_ff[k]  <= TW'(tex_q[0][k]) * TW'(wx7_inv) + TW'(tex_q[1][k]) * TW'(wx_ff[7]);
            bot_ff[k]  <= TW'(tex_q[2][k]) * TW'(wx7_inv) + TW'(tex_q[3][k]) * TW'(wx_ff[7]);
            near_ff[k] <= tex_q[0][k];
            if (!present_ff) begin
               out_ff[k] <= bts_pkg::WHITE_Q88;
            end else if (!filter_ff) begin
               out_ff[k] <= {near_ff[k], 8'h00};
            end else begin
               out_ff[k] <= bts_pkg::COLOR_W'(mix[k] >> SHIFT);
            end
         end
      end
   end

   assign rsp_if.valid = v_ff[9];
   assign rsp_if.red   = out_ff[0];
   assign rsp_if.green = out_ff[1];
   assign rsp_if.blue  = out_ff[2];

   `ASSERT_NEXT(a_stall_holds, clock, reset, !adv, $stable(v_ff))
   `ASSERT_ALWAYS(a_color_range, clock, reset,
      !v_ff[9] || (out_ff[0] <= bts_pkg::WHITE_Q88 && out_ff[1] <= bts_pkg::WHITE_Q88 &&
                   out_ff[2] <= bts_pkg::WHITE_Q88))
   `ASSERT_ALWAYS(a_white_absent, clock, reset,
      !(v_ff[9] && !present_ff) || (out_ff[0] == bts_pkg::WHITE_Q88))

endmodule
